>>> hw/rtl/iso_datetime_string_validator_unit_assert.svh
// Assertion macros shared by the validator checker.
`ifndef ISO_DATETIME_STRING_VALIDATOR_UNIT_ASSERT_SVH
`define ISO_DATETIME_STRING_VALIDATOR_UNIT_ASSERT_SVH

// Checked property with reset masking.
`define IDSV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define IDSV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/idsv_pkg.sv
// Shared types, constants and helper functions of the date/time validator.
package idsv_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_DATE  = 2'd0,
      MODE_TIME  = 2'd1,
      MODE_STAMP = 2'd2,
      MODE_BAD   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CH_OTHER,
      CH_DIGIT,
      CH_DASH,
      CH_COLON,
      CH_DOT,
      CH_T,
      CH_Z,
      CH_PLUS
   } char_class_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      mode_type       mode;
      logic           last;
   } item_type;

   // Two-digit decimal field times ten plus a digit, kept to 7 bits.
   function automatic logic [6:0] acc_digit(input logic [6:0] v, input logic [3:0] d);
      logic [10:0] t;
      t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {7'd0, d};
      return t[6:0];
   endfunction

   // (10*tens + units) mod 4 == 0, using 10 = 2 mod 4.
   function automatic logic div4_two_digit(input logic [3:0] tens, input logic [3:0] units);
      logic [4:0] s;
      s = {tens, 1'b0} + {1'b0, units};
      return s[1:0] == 2'b00;
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] lim;
      case (month)
         4'd2:                       lim = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    lim = 5'd30;
         default:                    lim = 5'd31;
      endcase
      return lim;
   endfunction

endpackage

>>> hw/rtl/iso_datetime_string_validator_unit.sv
// Top level of the streaming ISO 8601 date/time validator.
// Usage:
//  - Request channel (req_*): one byte of the string per request, with the format
//    mode (0 date, 1 time, 2 timestamp; taken from the first byte) and a last mark.
//  - Response channel (rsp_*): one response per string, on its last byte;
//    rsp_valid_res is 1 when the whole string matched grammar and ranges.
//  - Throughput: one request per cycle sustained while the queue is not full. The
//    back end retires one queued request per clock unless a held response blocks a last byte;
//    the front end only classifies the byte. A last byte accepted goes into the queue;
//    when the back end pops it, its result is registered in rsp_valid_ff (rsp_valid).
//  - A four-entry queue separates front and back end; req_stall rises when it is full.
//  - While rsp_stall holds a response, the back end keeps retiring non-last bytes
//    and waits only on the next last byte, so the queue fills and then stalls requests.
//  - Reset (synchronous, active high) empties the queue, drops any pending
//    response and returns the checker to the start of a string.
module iso_datetime_string_validator_unit import idsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic [1:0] req_mode,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     queue_empty;
   item_type head_item;

   idsv_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .req_mode      (req_mode),
      .req_last      (req_last),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   idsv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   idsv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (queue_empty),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

>>> hw/rtl/idsv_front.sv
// Front end: takes request bytes and classifies them for the queue.
module idsv_front import idsv_pkg::*; (
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic [1:0] req_mode,
   input  logic       req_last,
   input  logic       queue_full,
   output logic       push,
   output item_type   push_item
);

   char_class_type cls;

   always_comb begin
      unique case (req_character) inside
         [8'h30:8'h39]: cls = CH_DIGIT;
         8'h2D:         cls = CH_DASH;
         8'h3A:         cls = CH_COLON;
         8'h2E:         cls = CH_DOT;
         8'h54:         cls = CH_T;
         8'h5A:         cls = CH_Z;
         8'h2B:         cls = CH_PLUS;
         default:       cls = CH_OTHER;
      endcase
   end

   assign req_stall       = queue_full;
   assign push            = req_valid && !queue_full;
   assign push_item.cls   = cls;
   // digit value only meaningful for digits; low nibble of '0'..'9' is the value
   assign push_item.digit = (cls == CH_DIGIT) ? req_character[3:0] : 4'd0;
   assign push_item.mode  = mode_type'(req_mode);
   assign push_item.last  = req_last;

endmodule

>>> hw/rtl/idsv_queue.sv
// Short FIFO of classified requests between front and back end.
module idsv_queue import idsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic     [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic     [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic     [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/idsv_back.sv
// Back end: grammar state machine, field gathering, range checks and response register.
module idsv_back import idsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  item_type head_item,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     rsp_valid_res
);

   typedef enum logic [2:0] {
      SEC_DATE = 3'd0,
      SEC_HM   = 3'd1,
      SEC_SEC  = 3'd2,
      SEC_FRAC = 3'd3,
      SEC_ZONE = 3'd4,
      SEC_OFF  = 3'd5
   } section_type;

   section_type section_ff, section_in;
   logic [4:0]  position_ff, position_in;
   logic        failed_ff, failed_in;
   mode_type    mode_ff, mode_in;
   logic [3:0]  year_ff [4];
   logic [3:0]  year_in [4];
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [1:0]  frac_ff, frac_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_res_ff, rsp_res_in;

   logic        ok;

   assign pop           = !empty && (!head_item.last || !rsp_valid_ff || !rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   always_comb begin
      logic        dig;
      logic        adv;
      logic        leap;
      logic        date_ok;
      logic        time_ok;
      logic        complete;
      logic        stamp_end;
      logic [4:0]  lim;

      section_in  = section_ff;
      position_in = position_ff;
      failed_in   = failed_ff;
      mode_in     = mode_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      frac_in     = frac_ff;
      dig         = (head_item.cls == CH_DIGIT);
      adv         = 1'b0;

      // first byte of a string latches the mode
      if (section_ff == SEC_DATE && position_ff == 5'd0) begin
         mode_in = head_item.mode;
         if (head_item.mode == MODE_TIME) section_in = SEC_HM;
         if (head_item.mode == MODE_BAD)  failed_in  = 1'b1;
      end

      if (failed_in) begin
         adv = 1'b1;
      end else begin
         unique case (section_in)
            SEC_DATE: begin
               adv = 1'b1;
               if (position_in <= 5'd3) begin
                  if (dig) year_in[position_in[1:0]] = head_item.digit;
                  else failed_in = 1'b1;
               end else if (position_in == 5'd4 || position_in == 5'd7) begin
                  if (head_item.cls != CH_DASH) failed_in = 1'b1;
               end else if (position_in == 5'd5 || position_in == 5'd6) begin
                  if (dig) month_in = acc_digit(month_ff, head_item.digit);
                  else failed_in = 1'b1;
               end else if (position_in == 5'd8 || position_in == 5'd9) begin
                  if (dig) day_in = acc_digit(day_ff, head_item.digit);
                  else failed_in = 1'b1;
               end else if (position_in == 5'd10 && mode_in == MODE_STAMP &&
                            head_item.cls == CH_T) begin
                  section_in  = SEC_HM;
                  position_in = 5'd0;
                  adv         = 1'b0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            SEC_HM: begin
               if (position_in == 5'd5) begin
                  if (head_item.cls == CH_COLON) begin
                     section_in  = SEC_SEC;
                     position_in = 5'd0;
                  end else if (mode_in == MODE_STAMP && head_item.cls == CH_Z) begin
                     section_in  = SEC_ZONE;
                     position_in = 5'd0;
                  end else if (mode_in == MODE_STAMP &&
                               (head_item.cls == CH_PLUS || head_item.cls == CH_DASH)) begin
                     section_in  = SEC_OFF;
                     position_in = 5'd0;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else begin
                  adv = 1'b1;
                  if (position_in <= 5'd1) begin
                     if (dig) hour_in = acc_digit(hour_ff, head_item.digit);
                     else failed_in = 1'b1;
                  end else if (position_in == 5'd2) begin
                     if (head_item.cls != CH_COLON) failed_in = 1'b1;
                  end else if (position_in <= 5'd4) begin
                     if (dig) minute_in = acc_digit(minute_ff, head_item.digit);
                     else failed_in = 1'b1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
            end
            SEC_SEC: begin
               if (position_in == 5'd2) begin
                  if (head_item.cls == CH_DOT) begin
                     frac_in     = 2'd0;
                     section_in  = SEC_FRAC;
                     position_in = 5'd0;
                  end else if (mode_in == MODE_STAMP && head_item.cls == CH_Z) begin
                     section_in  = SEC_ZONE;
                     position_in = 5'd0;
                  end else if (mode_in == MODE_STAMP &&
                               (head_item.cls == CH_PLUS || head_item.cls == CH_DASH)) begin
                     section_in  = SEC_OFF;
                     position_in = 5'd0;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else begin
                  adv = 1'b1;
                  if (position_in <= 5'd1) begin
                     if (dig) second_in = acc_digit(second_ff, head_item.digit);
                     else failed_in = 1'b1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
            end
            SEC_FRAC: begin
               // fraction bytes do not move position
               if (dig && frac_ff != 2'd3) begin
                  frac_in = frac_ff + 2'd1;
               end else if (frac_ff != 2'd0) begin
                  if (mode_in == MODE_STAMP && head_item.cls == CH_Z) begin
                     section_in  = SEC_ZONE;
                     position_in = 5'd0;
                  end else if (mode_in == MODE_STAMP &&
                               (head_item.cls == CH_PLUS || head_item.cls == CH_DASH)) begin
                     section_in  = SEC_OFF;
                     position_in = 5'd0;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            SEC_OFF: begin
               adv = 1'b1;
               if (position_in == 5'd0 || position_in == 5'd1 ||
                   position_in == 5'd3 || position_in == 5'd4) begin
                  if (!dig) failed_in = 1'b1;
               end else if (position_in == 5'd2) begin
                  if (head_item.cls != CH_COLON) failed_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               // anything after 'Z'
               adv       = 1'b1;
               failed_in = 1'b1;
            end
         endcase
      end

      if (adv && position_in != 5'd31) begin
         position_in = position_in + 5'd1;
      end

      // leap year from the digits: century years use the upper two digits
      if (year_in[2] == 4'd0 && year_in[3] == 4'd0) begin
         leap = div4_two_digit(year_in[0], year_in[1]);
      end else begin
         leap = div4_two_digit(year_in[2], year_in[3]);
      end
      lim     = days_in_month(month_in[3:0], leap);
      date_ok = (month_in >= 7'd1) && (month_in <= 7'd12) &&
                (day_in >= 7'd1) && (day_in <= {2'b00, lim});
      time_ok = (hour_in < 7'd24) && (minute_in < 7'd60) && (second_in < 7'd60);
      complete  = (section_in == SEC_HM && position_in == 5'd5) ||
                  (section_in == SEC_SEC && position_in == 5'd2) ||
                  (section_in == SEC_FRAC && frac_in != 2'd0);
      stamp_end = complete || section_in == SEC_ZONE ||
                  (section_in == SEC_OFF && position_in == 5'd5);

      ok = 1'b0;
      if (!failed_in) begin
         unique case (mode_in)
            MODE_DATE:  ok = (section_in == SEC_DATE) && (position_in == 5'd10) && date_ok;
            MODE_TIME:  ok = complete && time_ok;
            MODE_STAMP: ok = stamp_end && date_ok && time_ok;
            default:    ok = 1'b0;
         endcase
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_res_in   = rsp_res_ff;

      if (pop && head_item.last) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = ok;
         section_in   = SEC_DATE;
         position_in  = 5'd0;
         failed_in    = 1'b0;
         mode_in      = MODE_DATE;
         year_in      = '{default: 4'd0};
         month_in     = 7'd0;
         day_in       = 7'd0;
         hour_in      = 7'd0;
         minute_in    = 7'd0;
         second_in    = 7'd0;
         frac_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff   <= SEC_DATE;
         position_ff  <= 5'd0;
         failed_ff    <= 1'b0;
         mode_ff      <= MODE_DATE;
         year_ff      <= '{default: 4'd0};
         month_ff     <= 7'd0;
         day_ff       <= 7'd0;
         hour_ff      <= 7'd0;
         minute_ff    <= 7'd0;
         second_ff    <= 7'd0;
         frac_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            section_ff  <= section_in;
            position_ff <= position_in;
            failed_ff   <= failed_in;
            mode_ff     <= mode_in;
            year_ff     <= year_in;
            month_ff    <= month_in;
            day_ff      <= day_in;
            hour_ff     <= hour_in;
            minute_ff   <= minute_in;
            second_ff   <= second_in;
            frac_ff     <= frac_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

endmodule

>>> hw/rtl/idsv_checker.sv
// Port-level checker for the validator and its bind to the top level.
`include "iso_datetime_string_validator_unit_assert.svh"

module idsv_checker import idsv_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_character,
   input logic [1:0] req_mode,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_valid_res
);

   localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              last_in;
   logic              rsp_out;
   logic              unused_fields;

   // strings whose last byte went in but whose response is not yet taken
   assign last_in       = req_valid && !req_stall && req_last;
   assign rsp_out       = rsp_valid && !rsp_stall;
   assign unused_fields = ^{req_character, req_mode};

   always_comb begin
      pending_in = pending_ff;
      if (last_in && !rsp_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_out && !last_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `IDSV_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_valid_res)), "stalled response changed")
   `IDSV_ASSERT(a_rsp_owed, clock, reset, rsp_valid |-> (pending_ff != '0 || unused_fields != unused_fields), "response without a finished string")
   `IDSV_ASSERT(a_pend_bound, clock, reset, 1'b1 |-> (pending_ff <= PEND_W'(QUEUE_DEPTH + 1)), "too many strings in flight")
   `IDSV_ASSERT_ALWAYS(a_rst_clear, clock, reset |=> (!rsp_valid && !req_stall), "reset left response or stall")

endmodule

bind iso_datetime_string_validator_unit idsv_checker u_idsv_checker (.*);
